// ----- rtl/vfc_pkg.sv -----
// shared types and constants of the voxel face culling block
`default_nettype none
package vfc_pkg;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int POS_X_W    = 6;
  localparam int POS_Y_W    = 7;
  localparam int POS_Z_W    = 6;
  localparam int BTYPE_W    = 6;
  localparam int WORLD_W    = 32;
  localparam int FACE_W     = 3;
  localparam int SIDE_W     = 3;
  localparam int NUM_FACES  = 6;
  // signed working width of neighbor coordinates
  localparam int COORD_W    = 12;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSP_MASK = 2'd3;

  // read slots: the six faces in output order, then the queried voxel itself
  typedef enum logic [FACE_W-1:0] {
    FACE_UP    = 3'd0,
    FACE_DOWN  = 3'd1,
    FACE_NORTH = 3'd2,
    FACE_SOUTH = 3'd3,
    FACE_EAST  = 3'd4,
    FACE_WEST  = 3'd5,
    SLOT_SELF  = 3'd6
  } slot_t;

  typedef struct packed {
    logic  accept;
    logic  issue;
    slot_t slot;
    logic  emit;
  } vfc_cmd_t;

  typedef struct packed {
    logic faces_left;
    logic out_free;
  } vfc_status_t;

endpackage
`default_nettype wire

// ----- rtl/vfc_ctrl.sv -----
// controller state machine: sequences store reads and face emission
`default_nettype none
module vfc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tuser,
  output logic                     s_axis_tready,
  input  wire vfc_pkg::vfc_status_t st,
  output vfc_pkg::vfc_cmd_t        cmd
);
  import vfc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_EMIT
  } state_t;

  state_t state;
  slot_t  slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot  <= SLOT_SELF;
    end else begin
      case (state)
        ST_IDLE: begin
          slot <= SLOT_SELF;
          if (s_axis_tvalid && s_axis_tuser == FUNC_QUERY) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (slot == SLOT_SELF) begin
            slot <= FACE_UP;
          end else if (slot == FACE_WEST) begin
            state <= ST_WAIT;
          end else begin
            slot <= slot_t'(slot + 3'd1);
          end
        end
        ST_WAIT: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!st.faces_left) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    cmd.accept = s_axis_tvalid && (state == ST_IDLE);
    cmd.issue  = (state == ST_READ);
    cmd.slot   = slot;
    cmd.emit   = (state == ST_EMIT) && st.faces_left && st.out_free;
  end

endmodule
`default_nettype wire

// ----- rtl/vfc_datapath.sv -----
// datapath: config registers, voxel store, neighbor tests and output register
`default_nettype none
module vfc_datapath #(
  parameter int CHUNK_SIDE   = 16,
  parameter int CHUNK_HEIGHT = 128,
  parameter int MAX_SIDE     = 4,
  parameter int TYPE_BITS    = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [vfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vfc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [vfc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [vfc_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  output logic                                   m_axis_tlast,
  input  wire vfc_pkg::vfc_cmd_t                 cmd,
  output vfc_pkg::vfc_status_t                   st
);
  import vfc_pkg::*;

  localparam int SPAN  = MAX_SIDE * CHUNK_SIDE;
  localparam int DEPTH = SPAN * SPAN * CHUNK_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (SPAN > 1) ? $clog2(SPAN) : 1;
  localparam int YW    = (CHUNK_HEIGHT > 1) ? $clog2(CHUNK_HEIGHT) : 1;
  localparam int TW    = TYPE_BITS;
  localparam logic signed [COORD_W-1:0] Y_LIM = COORD_W'(CHUNK_HEIGHT);

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y,
                                              input logic [XW-1:0] z);
    cell_addr = AW'(x) * AW'(SPAN * CHUNK_HEIGHT) + AW'(z) * AW'(CHUNK_HEIGHT) + AW'(y);
  endfunction

  // configuration
  logic [SIDE_W-1:0]     sector_side;
  logic [WORLD_W-1:0]    origin_x;
  logic [WORLD_W-1:0]    origin_z;
  logic [CFG_DATA_W-1:0] transparent_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_side      <= SIDE_W'(1);
      origin_x         <= '0;
      origin_z         <= '0;
      transparent_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SECTOR_SIDE: sector_side      <= cfg_data[SIDE_W-1:0];
        CFG_ORIGIN_X:    origin_x         <= cfg_data[WORLD_W-1:0];
        CFG_ORIGIN_Z:    origin_z         <= cfg_data[WORLD_W-1:0];
        CFG_TRANSP_MASK: transparent_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [SIDE_W-1:0]         side_sat;
  logic signed [COORD_W-1:0] span_now;

  always_comb begin
    side_sat = (int'(sector_side) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : sector_side;
    span_now = COORD_W'(side_sat) * COORD_W'(CHUNK_SIDE);
  end

  // input fields
  logic [POS_X_W-1:0] in_x;
  logic [POS_Y_W-1:0] in_y;
  logic [POS_Z_W-1:0] in_z;
  logic               in_present;
  logic [BTYPE_W-1:0] in_btype;

  assign in_x       = s_axis_tdata[5:0];
  assign in_y       = s_axis_tdata[12:6];
  assign in_z       = s_axis_tdata[18:13];
  assign in_present = s_axis_tdata[19];
  assign in_btype   = s_axis_tdata[25:20];

  // voxel store write side
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [TW:0]   wr_word;

  always_comb begin
    wr_en   = cmd.accept && (s_axis_tuser == FUNC_WRITE) && (int'(in_x) < SPAN) &&
              (int'(in_z) < SPAN) && (int'(in_y) < CHUNK_HEIGHT);
    wr_addr = cell_addr(XW'(COORD_W'(in_x)), YW'(COORD_W'(in_y)), XW'(COORD_W'(in_z)));
    wr_word = in_present ? {1'b1, in_btype[TW-1:0]} : '0;
  end

  // latched query
  logic [POS_X_W-1:0] q_x;
  logic [POS_Y_W-1:0] q_y;
  logic [POS_Z_W-1:0] q_z;

  always_ff @(posedge clk) begin
    if (cmd.accept && s_axis_tuser == FUNC_QUERY) begin
      q_x <= in_x;
      q_y <= in_y;
      q_z <= in_z;
    end
  end

  // neighbor coordinate and range check for the slot being read
  logic signed [COORD_W-1:0] nx;
  logic signed [COORD_W-1:0] ny;
  logic signed [COORD_W-1:0] nz;
  logic                      rd_ok;
  logic [AW-1:0]             rd_addr;

  always_comb begin
    nx = signed'(COORD_W'(q_x));
    ny = signed'(COORD_W'(q_y));
    nz = signed'(COORD_W'(q_z));
    case (cmd.slot)
      FACE_UP:    ny = ny + COORD_W'(1);
      FACE_DOWN:  ny = ny - COORD_W'(1);
      FACE_NORTH: nz = nz + COORD_W'(1);
      FACE_SOUTH: nz = nz - COORD_W'(1);
      FACE_EAST:  nx = nx + COORD_W'(1);
      FACE_WEST:  nx = nx - COORD_W'(1);
      default: ;
    endcase
    rd_ok   = (nx >= 0) && (nx < span_now) && (nz >= 0) && (nz < span_now) &&
              (ny >= 0) && (ny < Y_LIM);
    rd_addr = rd_ok ? cell_addr(XW'(nx), YW'(ny), XW'(nz)) : '0;
  end

  // voxel store: bit TW present, low bits type
  logic [TW:0] voxel_mem [DEPTH];
  logic [TW:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      voxel_mem[wr_addr] <= wr_word;
    end
    if (cmd.issue) begin
      rd_word <= voxel_mem[rd_addr];
    end
  end

  logic  rd_valid;
  slot_t rd_slot;
  logic  rd_ok_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
    end
    rd_slot <= cmd.slot;
    rd_ok_q <= rd_ok;
  end

  // evaluation of returned entries
  logic                 self_ok;
  logic [TW-1:0]        self_type;
  logic [NUM_FACES-1:0] vis;
  logic                 nb_present;
  logic [TW-1:0]        nb_type;
  logic                 nb_vis;

  always_comb begin
    nb_present = rd_ok_q && rd_word[TW];
    nb_type    = rd_word[TW-1:0];
    nb_vis     = !nb_present ||
                 ((nb_type != self_type) && transparent_mask[BTYPE_W'(nb_type)]);
  end

  // emission pick: lowest face still pending
  logic [FACE_W-1:0]    pick;
  logic [NUM_FACES-1:0] vis_rest;

  always_comb begin
    pick = '0;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (vis[f]) begin
        pick = FACE_W'(f);
      end
    end
    vis_rest       = vis;
    vis_rest[pick] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && s_axis_tuser == FUNC_QUERY) begin
      vis <= '0;
    end else if (rd_valid) begin
      if (rd_slot == SLOT_SELF) begin
        self_ok   <= rd_ok_q && rd_word[TW];
        self_type <= rd_word[TW-1:0];
      end else begin
        vis[rd_slot] <= self_ok && nb_vis;
      end
    end else if (cmd.emit) begin
      vis <= vis_rest;
    end
  end

  // output register
  logic [WORLD_W-1:0] o_wx;
  logic [POS_Y_W-1:0] o_wy;
  logic [WORLD_W-1:0] o_wz;
  logic [BTYPE_W-1:0] o_type;
  logic [FACE_W-1:0]  o_face;
  logic               o_transp;
  logic               o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (cmd.emit) begin
      o_wx     <= WORLD_W'(q_x) + origin_x;
      o_wy     <= q_y;
      o_wz     <= WORLD_W'(q_z) + origin_z;
      o_type   <= BTYPE_W'(self_type);
      o_face   <= pick;
      o_transp <= transparent_mask[BTYPE_W'(self_type)];
      o_last   <= (vis_rest == '0);
    end
  end

  assign m_axis_tdata = {7'b0, o_transp, o_face, o_type, o_wz, o_wy, o_wx};
  assign m_axis_tlast = o_last;

  always_comb begin
    st.faces_left = (vis != '0);
    st.out_free   = !m_axis_tvalid || m_axis_tready;
  end

endmodule
`default_nettype wire

// ----- rtl/voxel_face_culling_top.sv -----
// top level of the voxel face culling block
// A write request (tuser 0) stores one voxel and leaves the block ready for the next request.
// A query request (tuser 1) reads the queried voxel and its six neighbors one per cycle
// from a single-read-port voxel store, then sends one result per visible face, one per
// cycle while the output is not stalled. The result register lets the next request be
// taken while the final face still waits downstream. The store has no reset; query only
// voxels and in-sector neighbors that have been written.
`default_nettype none
module voxel_face_culling_top #(
  parameter int CHUNK_SIDE   = 16,
  parameter int CHUNK_HEIGHT = 128,
  parameter int MAX_SIDE     = 4,
  parameter int TYPE_BITS    = 6
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [vfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vfc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x[5:0], pos_y[12:6], pos_z[18:13], present[19], block_type[25:20], zeros
  input  wire logic [vfc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func[0]
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // world_x[31:0], world_y[38:32], world_z[70:39], face_type[76:71], face[79:77],
  // is_transparent[80], zeros
  output logic [vfc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast
);
  import vfc_pkg::*;

  vfc_cmd_t    cmd;
  vfc_status_t st;

  vfc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .st            (st),
    .cmd           (cmd)
  );

  vfc_datapath #(
    .CHUNK_SIDE   (CHUNK_SIDE),
    .CHUNK_HEIGHT (CHUNK_HEIGHT),
    .MAX_SIDE     (MAX_SIDE),
    .TYPE_BITS    (TYPE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd           (cmd),
    .st            (st)
  );

endmodule
`default_nettype wire

// ----- rtl/vfc_checker.sv -----
// port-level checker for the voxel face culling block and its bind
`default_nettype none
module vfc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [vfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                           m_axis_tlast
);
  import vfc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a write request leaves the block ready
  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_WRITE |=> s_axis_tready)
    else $error("not ready after write request");

  // a query request makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_QUERY |=> !s_axis_tready)
    else $error("ready right after query request");

  // faces of one query come without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a query's faces");

  // no new request while a query still has faces pending
  a_busy_mid_query: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("ready while faces pending");

endmodule

bind voxel_face_culling_top vfc_checker u_vfc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
